FILE: design/mkpd_pkg.sv
// constants, phase encoding and helper function for the matrix keypad scanner
// no dependencies
package mkpd_pkg;

    localparam int ROWS      = 5;
    localparam int COLUMNS   = 8;
    localparam int ROW_IDX_W = 3;
    localparam int COL_IDX_W = 3;
    localparam int CNT_W     = 8;
    localparam int CODE_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEBOUNCE = 1'b1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd2;
    localparam logic [ROWS-1:0]  ROW_FIRST      = 5'b00001;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_PRESSED  = 4'b0010,
        PH_HELD     = 4'b0100,
        PH_RELEASED = 4'b1000
    } t_phase;

    // index of the lowest set bit, zero when none is set
    function automatic logic [2:0] f_low_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/matrix_keypad_scan_debounce.sv
// Matrix keypad scanner with press and release debounce, single module
// depends on mkpd_pkg
//
// One input item is one scan tick: the column lines sensed under the current
// row drive. Every item yields exactly one result item with the row drive to
// apply for the next tick, a key flag and the key code (row index * 16 + column
// index) on the tick a debounced press and release completes. An item passes
// through the next-state logic straight into the result register; a new item
// is taken every cycle as long as the result register is empty or being read.
// Debounce counts of zero last 256 ticks.
module matrix_keypad_scan_debounce
    import mkpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] column_sense
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [4:0] row_drive, [11:5] key_value
    output logic                   m_axis_tuser    // [0] key_valid
);

    logic [CNT_W-1:0]     r_press_db;
    logic [CNT_W-1:0]     r_release_db;

    t_phase               r_phase, n_phase;
    logic [ROWS-1:0]      r_row, n_row;
    logic [COL_IDX_W-1:0] r_col, n_col;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CODE_W-1:0]    r_code, n_code;
    logic                 r_pend, n_pend;

    logic                 r_out_valid;
    logic [ROWS-1:0]      r_out_row;
    logic                 r_out_key;
    logic [CODE_W-1:0]    r_out_code;

    logic                 key_hit;
    logic [CODE_W-1:0]    hit_code;

    logic [COLUMNS-1:0]   cols;
    logic                 held_closed;
    logic [CNT_W-1:0]     cnt_dec;
    logic [COL_IDX_W-1:0] low_col;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cols        = s_axis_tdata[COLUMNS-1:0];
    assign held_closed = cols[r_col];
    assign cnt_dec     = r_cnt - 1'b1;
    assign low_col     = f_low_index(8'(cols));
    assign row_idx     = f_low_index(8'(r_row));

    always_comb begin
        n_phase  = r_phase;
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_code   = r_code;
        n_pend   = r_pend;
        key_hit  = 1'b0;
        hit_code = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (cols != '0) begin
                    n_col   = low_col;
                    n_phase = PH_PRESSED;
                    n_cnt   = r_press_db;
                end else begin
                    n_row = {r_row[ROWS-2:0], r_row[ROWS-1]};
                end
            end
            PH_PRESSED: begin
                if (!held_closed) begin
                    n_phase = PH_RELEASED;
                    n_cnt   = r_release_db;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_phase = PH_HELD;
                        n_code  = {row_idx, 1'b0, r_col};
                        n_pend  = 1'b1;
                    end
                end
            end
            PH_HELD: begin
                if (!held_closed) begin
                    n_phase = PH_RELEASED;
                    n_cnt   = r_release_db;
                end
            end
            PH_RELEASED: begin
                if (held_closed) begin
                    n_phase = PH_PRESSED;
                    n_cnt   = r_press_db;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_phase = PH_IDLE;
                        if (r_pend) begin
                            key_hit  = 1'b1;
                            hit_code = r_code;
                            n_pend   = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_db   <= DEBOUNCE_RESET;
            r_release_db <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESS_DEBOUNCE:   r_press_db   <= i_cfg_data;
                CFG_RELEASE_DEBOUNCE: r_release_db <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_row   <= ROW_FIRST;
            r_col   <= '0;
            r_cnt   <= '0;
            r_code  <= '0;
            r_pend  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_code  <= n_code;
            r_pend  <= n_pend;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_row  <= n_row;
            r_out_key  <= key_hit;
            r_out_code <= hit_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - ROWS - CODE_W)'(0), r_out_code, r_out_row};
    assign m_axis_tuser  = r_out_key;

endmodule
